FILE: sv/u8e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8e_pkg
// Shared types and constants for the UTF-32 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u8e_pkg;

  typedef enum logic [1:0] {
    STAT_DATA     = 2'd0,
    STAT_BAD_MARK = 2'd1,
    STAT_RANGE    = 2'd2
  } status_t;

  // One classified word: up to four output bytes, index of the last one
  // and the status that every byte of it carries.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    status_t         status;
  } entry_t;

endpackage

FILE: sv/u8e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8e_front
// Accepts words, tracks the byte order mark and encodes each code point.
// ----------------------------------------------------------------------------
module u8e_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_first_byte,
  input  logic [7:0]       in_second_byte,
  input  logic [7:0]       in_third_byte,
  input  logic [7:0]       in_fourth_byte,
  input  logic             q_full,
  output logic             q_push,
  output u8e_pkg::entry_t  q_wdata
);

  localparam logic [31:0] MAX_1B = 32'h0000_007f;
  localparam logic [31:0] MAX_2B = 32'h0000_07ff;
  localparam logic [31:0] MAX_3B = 32'h0000_ffff;
  localparam logic [31:0] MAX_CP = 32'h0010_ffff;

  logic        mark_seen_r, mark_seen_nxt;
  logic        big_endian_r, big_endian_nxt;
  logic        halted_r, halted_nxt;
  logic        accept;
  logic        mark_le, mark_be;
  logic [31:0] cp;
  u8e_pkg::entry_t enc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign mark_le = (in_first_byte == 8'hff) && (in_second_byte == 8'hfe) &&
                   (in_third_byte == 8'h00) && (in_fourth_byte == 8'h00);
  assign mark_be = (in_first_byte == 8'h00) && (in_second_byte == 8'h00) &&
                   (in_third_byte == 8'hfe) && (in_fourth_byte == 8'hff);

  assign cp = big_endian_r ?
              {in_first_byte, in_second_byte, in_third_byte, in_fourth_byte} :
              {in_fourth_byte, in_third_byte, in_second_byte, in_first_byte};

  always_comb begin
    enc = '0;
    enc.status = u8e_pkg::STAT_DATA;
    if (cp <= MAX_1B) begin
      enc.bytes[0] = {1'b0, cp[6:0]};
      enc.last_idx = 2'd0;
    end else if (cp <= MAX_2B) begin
      enc.bytes[0] = {3'b110, cp[10:6]};
      enc.bytes[1] = {2'b10, cp[5:0]};
      enc.last_idx = 2'd1;
    end else if (cp <= MAX_3B) begin
      enc.bytes[0] = {4'b1110, cp[15:12]};
      enc.bytes[1] = {2'b10, cp[11:6]};
      enc.bytes[2] = {2'b10, cp[5:0]};
      enc.last_idx = 2'd2;
    end else if (cp <= MAX_CP) begin
      enc.bytes[0] = {5'b11110, cp[20:18]};
      enc.bytes[1] = {2'b10, cp[17:12]};
      enc.bytes[2] = {2'b10, cp[11:6]};
      enc.bytes[3] = {2'b10, cp[5:0]};
      enc.last_idx = 2'd3;
    end else begin
      enc.status = u8e_pkg::STAT_RANGE;
    end
  end

  always_comb begin
    mark_seen_nxt  = mark_seen_r;
    big_endian_nxt = big_endian_r;
    halted_nxt     = halted_r;
    q_push         = 1'b0;
    q_wdata        = enc;
    if (accept && !halted_r) begin
      if (!mark_seen_r) begin
        if (mark_le || mark_be) begin
          mark_seen_nxt  = 1'b1;
          big_endian_nxt = mark_be;
        end else begin
          // bad mark: report once, then drop everything until reset
          halted_nxt      = 1'b1;
          q_push          = 1'b1;
          q_wdata         = '0;
          q_wdata.status  = u8e_pkg::STAT_BAD_MARK;
        end
      end else begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_seen_r  <= 1'b0;
      big_endian_r <= 1'b0;
      halted_r     <= 1'b0;
    end else begin
      mark_seen_r  <= mark_seen_nxt;
      big_endian_r <= big_endian_nxt;
      halted_r     <= halted_nxt;
    end
  end

endmodule

FILE: sv/u8e_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8e_queue
// Two-entry queue of encoded words between front and back.
// ----------------------------------------------------------------------------
module u8e_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8e_pkg::entry_t  wdata,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output u8e_pkg::entry_t  rdata
);

  u8e_pkg::entry_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: sv/u8e_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8e_back
// Serialises queued words into output bytes through an output register.
// ----------------------------------------------------------------------------
module u8e_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  u8e_pkg::entry_t  q_rdata,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_is_last,
  output logic [1:0]       out_status
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_is_last_r;
  logic [1:0] out_status_r;
  logic [1:0] idx_r, idx_nxt;
  logic       load;
  logic       at_last;

  assign load    = q_not_empty && (!out_valid_r || out_ready);
  assign at_last = (idx_r == q_rdata.last_idx);
  assign q_pop   = load && at_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = at_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r    <= q_rdata.bytes[idx_r];
      out_is_last_r <= at_last;
      out_status_r  <= q_rdata.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_last = out_is_last_r;
  assign out_status  = out_status_r;

endmodule

FILE: sv/utf32_to_utf8_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf32_to_utf8_encoder
// UTF-32 word stream in, UTF-8 byte stream out.
// ----------------------------------------------------------------------------
// The first word after reset must be a byte order mark (FF FE 00 00 for
// little-endian, 00 00 FE FF for big-endian); it gives no output. Any other
// first word gives one byte with status 1 and the block then drops all words
// until reset. Each later word is encoded and queued; the output side sends
// one byte per cycle while out_ready is high and a word is queued, and a
// word gives 1 to 4 bytes, set by its UTF-8 length. Code points above
// 0x10FFFF give one zero byte with status 2. The input is ready whenever the
// two-word queue has room, independent of the output handshake.
module utf32_to_utf8_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_first_byte,
  input  logic [7:0] in_second_byte,
  input  logic [7:0] in_third_byte,
  input  logic [7:0] in_fourth_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_last,
  output logic [1:0] out_status
);

  logic            q_full, q_push, q_pop, q_not_empty;
  u8e_pkg::entry_t q_wdata, q_rdata;

  u8e_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_first_byte  (in_first_byte),
    .in_second_byte (in_second_byte),
    .in_third_byte  (in_third_byte),
    .in_fourth_byte (in_fourth_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  u8e_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  u8e_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_is_last (out_is_last),
    .out_status  (out_status)
  );

endmodule
